[rtl/core/drfs_pkg.sv]
// Types and constants shared by the data-row field splitter modules.
package drfs_pkg;

    typedef enum logic [2:0] {
        PH_CNT_HI = 3'd0,
        PH_CNT_LO = 3'd1,
        PH_LEN0   = 3'd2,
        PH_LEN1   = 3'd3,
        PH_LEN2   = 3'd4,
        PH_LEN3   = 3'd5,
        PH_VALUE  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        K_HEADER = 2'd0,
        K_BYTE   = 2'd1,
        K_ROW    = 2'd2,
        K_ERROR  = 2'd3
    } t_kind;

    typedef enum logic {
        E_INCOMPLETE = 1'b0,
        E_INVALID    = 1'b1
    } t_err;

    typedef struct packed {
        t_phase      phase;
        logic [30:0] byte_position;
        logic [14:0] columns_left;
        logic [14:0] column_counter;
        logic [31:0] gather_shift;
        logic [30:0] value_bytes_left;
        logic        discard_flag;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [14:0] column_number;
        logic        is_null;
        logic [30:0] value_len;
        logic [7:0]  value_byte;
        logic        value_end;
        t_err        error_code;
        logic        last_of_item;
    } t_result;

    typedef struct packed {
        logic [1:0] nres;
        t_result    res0;
        t_result    res1;
    } t_step;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    function automatic t_result f_res(t_kind kind, logic [14:0] col, logic nul,
                                      logic [30:0] vlen, logic [7:0] vbyte,
                                      logic vend, t_err ecode);
        t_result r;
        r.kind          = kind;
        r.column_number = col;
        r.is_null       = nul;
        r.value_len     = vlen;
        r.value_byte    = vbyte;
        r.value_end     = vend;
        r.error_code    = ecode;
        r.last_of_item  = 1'b0;
        return r;
    endfunction

endpackage

[rtl/core/drfs_step.sv]
// Per-byte parse step: next parser state and the results caused by one transfer.
module drfs_step
    import drfs_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_data_byte,
    input  logic [30:0] i_payload_length,
    input  logic        i_has_byte,
    output t_state      o_next,
    output t_step       o_step
);

    function automatic logic f_left_ge(logic [30:0] len, logic [30:0] pos,
                                       logic [31:0] need);
        logic [31:0] diff;
        diff = {1'b0, len} - {1'b0, pos};
        return (pos <= len) && (diff >= need);
    endfunction

    t_state      n_st;
    t_result     res0;
    t_result     res1;
    logic [1:0]  nres;
    logic        fin;
    logic        do_adv;
    logic [14:0] adv_cl;
    logic [30:0] len;
    logic [30:0] pos;
    logic [15:0] cnt;
    logic [31:0] v;
    logic [30:0] vbl;
    t_result     adv_res;

    always_comb begin
        n_st    = i_state;
        res0    = '0;
        res1    = '0;
        nres    = 2'd0;
        fin     = 1'b0;
        do_adv  = 1'b0;
        adv_cl  = '0;
        adv_res = '0;
        len     = i_payload_length;
        pos     = i_state.byte_position + 31'd1;
        cnt     = {i_state.gather_shift[7:0], i_data_byte};
        v       = {i_state.gather_shift[23:0], i_data_byte};
        vbl     = i_state.value_bytes_left;

        if (!i_has_byte) begin
            if (i_state.byte_position == '0 && i_state.phase == PH_CNT_HI &&
                !i_state.discard_flag) begin
                res0 = f_res(K_ERROR, '0, 1'b0, '0, '0, 1'b0, E_INCOMPLETE);
                nres = 2'd1;
            end
        end else begin
            if (!i_state.discard_flag) begin
                case (i_state.phase)
                    PH_CNT_HI: begin
                        if (len < 31'd2) begin
                            res0 = f_res(K_ERROR, '0, 1'b0, '0, '0, 1'b0, E_INCOMPLETE);
                            nres = 2'd1;
                            fin  = 1'b1;
                        end else begin
                            n_st.gather_shift = {24'd0, i_data_byte};
                            n_st.phase        = PH_CNT_LO;
                        end
                    end
                    PH_CNT_LO: begin
                        if (cnt[15]) begin
                            res0 = f_res(K_ERROR, '0, 1'b0, '0, '0, 1'b0, E_INVALID);
                            nres = 2'd1;
                            fin  = 1'b1;
                        end else if (len < 31'd2 ||
                                     {16'd0, cnt[14:0]} > ((len - 31'd2) >> 2)) begin
                            res0 = f_res(K_ERROR, '0, 1'b0, '0, '0, 1'b0, E_INCOMPLETE);
                            nres = 2'd1;
                            fin  = 1'b1;
                        end else begin
                            n_st.columns_left   = cnt[14:0];
                            n_st.column_counter = '0;
                            do_adv              = 1'b1;
                            adv_cl              = cnt[14:0];
                        end
                    end
                    PH_LEN0: begin
                        n_st.gather_shift = v;
                        n_st.phase        = PH_LEN1;
                    end
                    PH_LEN1: begin
                        n_st.gather_shift = v;
                        n_st.phase        = PH_LEN2;
                    end
                    PH_LEN2: begin
                        n_st.gather_shift = v;
                        n_st.phase        = PH_LEN3;
                    end
                    PH_LEN3: begin
                        if (v == 32'hFFFF_FFFF) begin
                            res0 = f_res(K_HEADER, i_state.column_counter, 1'b1, '0, '0,
                                         1'b0, E_INCOMPLETE);
                            nres = 2'd1;
                            do_adv = 1'b1;
                        end else if (v[31]) begin
                            res0 = f_res(K_ERROR, '0, 1'b0, '0, '0, 1'b0, E_INVALID);
                            nres = 2'd1;
                            fin  = 1'b1;
                        end else if (!f_left_ge(len, pos, v)) begin
                            res0 = f_res(K_ERROR, '0, 1'b0, '0, '0, 1'b0, E_INCOMPLETE);
                            nres = 2'd1;
                            fin  = 1'b1;
                        end else begin
                            res0 = f_res(K_HEADER, i_state.column_counter, 1'b0, v[30:0],
                                         '0, 1'b0, E_INCOMPLETE);
                            nres = 2'd1;
                            if (v == '0) begin
                                do_adv = 1'b1;
                            end else begin
                                n_st.value_bytes_left = v[30:0];
                                n_st.phase            = PH_VALUE;
                            end
                        end
                    end
                    default: begin
                        if (vbl != '0) begin
                            vbl = vbl - 31'd1;
                        end
                        n_st.value_bytes_left = vbl;
                        res0 = f_res(K_BYTE, i_state.column_counter, 1'b0, '0, i_data_byte,
                                     (vbl == '0), E_INCOMPLETE);
                        nres = 2'd1;
                        do_adv = (vbl == '0);
                    end
                endcase

                // close the column before moving on
                if (do_adv && i_state.phase != PH_CNT_LO) begin
                    n_st.column_counter = i_state.column_counter + 15'd1;
                    n_st.columns_left   = i_state.columns_left - 15'd1;
                    adv_cl              = i_state.columns_left - 15'd1;
                end

                if (do_adv) begin
                    if (adv_cl == '0) begin
                        if (pos != len) begin
                            adv_res = f_res(K_ERROR, '0, 1'b0, '0, '0, 1'b0, E_INVALID);
                        end else begin
                            adv_res = f_res(K_ROW, '0, 1'b0, '0, '0, 1'b0, E_INCOMPLETE);
                        end
                        fin = 1'b1;
                    end else if (!f_left_ge(len, pos, 32'd4)) begin
                        adv_res = f_res(K_ERROR, '0, 1'b0, '0, '0, 1'b0, E_INCOMPLETE);
                        fin     = 1'b1;
                    end else begin
                        n_st.gather_shift = '0;
                        n_st.phase        = PH_LEN0;
                    end
                    if (fin) begin
                        if (nres == 2'd0) begin
                            res0 = adv_res;
                        end else begin
                            res1 = adv_res;
                        end
                        nres = nres + 2'd1;
                    end
                end
            end

            if (pos >= len) begin
                n_st = '0;
            end else begin
                n_st.byte_position = pos;
                if (fin) begin
                    n_st.discard_flag = 1'b1;
                end
            end
        end

        if (nres == 2'd2) begin
            res1.last_of_item = 1'b1;
        end else begin
            res0.last_of_item = 1'b1;
        end
    end

    assign o_next      = n_st;
    assign o_step.nres = nres;
    assign o_step.res0 = res0;
    assign o_step.res1 = res1;

endmodule

[rtl/core/data_row_field_splitter.sv]
// Top level of the data-row field splitter: parser state, result queue and stream ports.
//
// Takes one data-row payload byte per transfer and returns column headers, value
// bytes, a row-complete mark or an error. A byte is accepted in every cycle while
// the two-entry result queue has a free entry; the parse of a byte completes in the
// cycle it is accepted and its results are registered in the result queue before
// they reach the output. A byte that causes one result sustains one byte per cycle
// while m_axis_tready is high; a byte that causes two results (a column header or final
// value byte that also ends the column with a row-complete or error) holds the single
// output port for both, one after the other. Bytes with no result use no queue entry.
module data_row_field_splitter
    import drfs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // data_byte [7:0], payload_length [38:8], zero [39]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // has_byte [0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // column_number [14:0], is_null [15], value_len [46:16], value_byte [54:47],
    // value_end [55], error_code [56], zero [63:57]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind [1:0]
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    t_state     r_state;
    t_state     n_state;
    t_step      step;
    t_step      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic       r_sub;
    logic [1:0] r_cnt;
    logic       in_xfer;
    logic       push;
    logic       pop;
    t_step      head;
    t_result    cur;

    drfs_step u_step (
        .i_state          (r_state),
        .i_data_byte      (s_axis_tdata[7:0]),
        .i_payload_length (s_axis_tdata[38:8]),
        .i_has_byte       (s_axis_tuser),
        .o_next           (n_state),
        .o_step           (step)
    );

    assign s_axis_tready = (r_cnt != 2'd2);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign push          = in_xfer && (step.nres != 2'd0);

    assign head          = r_q[r_rp];
    assign cur           = r_sub ? head.res1 : head.res0;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready && (r_sub || head.nres != 2'd2);

    assign m_axis_tdata  = {7'd0, cur.error_code, cur.value_end, cur.value_byte,
                            cur.value_len, cur.is_null, cur.column_number};
    assign m_axis_tuser  = cur.kind;
    assign m_axis_tlast  = cur.last_of_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_sub   <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pop) begin
                    r_rp  <= ~r_rp;
                    r_sub <= 1'b0;
                end else begin
                    r_sub <= 1'b1;
                end
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= step;
        end
    end

endmodule
